// ===== src/asmt_pkg.sv =====
// ----------------------------------------------------------------------------
// asmt_pkg
// Shared types and constants for the ANSI SGR to markup translator: channel
// payloads, controller states, command and status groups, character codes.
// ----------------------------------------------------------------------------
`default_nettype none

package asmt_pkg;

    // Default sizes
    localparam int ESC_WINDOW_DEF   = 16;
    localparam int OUT_CAPACITY_DEF = 8000;
    localparam int MAX_RESULTS      = 40;
    localparam int RES_W            = $clog2(MAX_RESULTS + 1);

    // Character codes
    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_PCT  = 8'h25;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_MIN  = 8'h2D;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_LBK  = 8'h5B;
    localparam logic [7:0] CH_RBK  = 8'h5D;
    localparam logic [7:0] CH_LBR  = 8'h7B;
    localparam logic [7:0] CH_RBR  = 8'h7D;
    localparam logic [7:0] CH_LPR  = 8'h28;
    localparam logic [7:0] CH_RPR  = 8'h29;
    localparam logic [7:0] CH_LB   = 8'h62;
    localparam logic [7:0] CH_LC   = 8'h63;
    localparam logic [7:0] CH_LM   = 8'h6D;
    localparam logic [7:0] CH_LR   = 8'h72;

    // Number parser phases
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_SIGN  = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_end;
    } asmt_in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       run_last;
        logic       string_done;
        logic       truncated;
    } asmt_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HANDLE,
        ST_EMIT,
        ST_FETCH,
        ST_ENDCHK,
        ST_DRAIN_GO,
        ST_DRAIN_WAIT
    } asmt_state_t;

    typedef enum logic [1:0] {
        SRC_IN,
        SRC_MEM,
        SRC_EXTRA
    } asmt_src_t;

    // Controller to datapath / output buffer
    typedef struct packed {
        logic accept;
        logic handle;
        logic emit;
        logic fetch;
        logic endchk;
        logic drain_start;
        logic finish;
    } asmt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic list_done;
        logic more;
        logic in_end;
        logic end_idle;
    } asmt_dp_status_t;

    // Output buffer to controller and datapath
    typedef struct packed {
        logic has_results;
        logic full;
        logic drain_done;
    } asmt_ob_status_t;

endpackage

`default_nettype wire

// ===== src/asmt_ctrl.sv =====
// ----------------------------------------------------------------------------
// asmt_ctrl
// Sequencer: accepts a byte, runs handling and character emission, walks
// the escape window on a literal flush, closes the string and drains results.
// ----------------------------------------------------------------------------
`default_nettype none

module asmt_ctrl (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        in_valid,
    input  asmt_pkg::asmt_dp_status_t  dp_status,
    input  asmt_pkg::asmt_ob_status_t  ob_status,
    output asmt_pkg::asmt_cmd_t        cmd,
    output logic                       idle
);
    import asmt_pkg::*;

    asmt_state_t state_reg;
    asmt_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_HANDLE;
                end
            end
            ST_HANDLE:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (dp_status.list_done)
                begin
                    if (dp_status.more)
                    begin
                        state_next = ST_FETCH;
                    end
                    else if (dp_status.in_end)
                    begin
                        state_next = ST_ENDCHK;
                    end
                    else if (ob_status.has_results)
                    begin
                        state_next = ST_DRAIN_GO;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_HANDLE;
            end
            ST_ENDCHK:
            begin
                if (dp_status.end_idle)
                begin
                    state_next = ST_DRAIN_GO;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_DRAIN_GO:
            begin
                state_next = ST_DRAIN_WAIT;
            end
            ST_DRAIN_WAIT:
            begin
                if (ob_status.drain_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd  = '0;
        idle = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                idle       = 1'b1;
                cmd.accept = in_valid;
            end
            ST_HANDLE:
            begin
                cmd.handle = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = !dp_status.list_done;
            end
            ST_FETCH:
            begin
                cmd.fetch = 1'b1;
            end
            ST_ENDCHK:
            begin
                cmd.endchk = !dp_status.end_idle;
            end
            ST_DRAIN_GO:
            begin
                cmd.drain_start = 1'b1;
            end
            ST_DRAIN_WAIT:
            begin
                cmd.finish = ob_status.drain_done;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/asmt_datapath.sv =====
// ----------------------------------------------------------------------------
// asmt_datapath
// Per-string state, escape window store, number parser and the character
// list produced by handling one byte; writes characters to the result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module asmt_datapath #(
    parameter int ESC_WINDOW   = asmt_pkg::ESC_WINDOW_DEF,
    parameter int OUT_CAPACITY = asmt_pkg::OUT_CAPACITY_DEF
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  asmt_pkg::asmt_cmd_t        cmd,
    input  asmt_pkg::asmt_in_t         in_data,
    input  wire                        cfg_we,
    input  wire                        cfg_data,
    input  asmt_pkg::asmt_ob_status_t  ob_status,
    output asmt_pkg::asmt_dp_status_t  dp_status,
    output logic                       wr_en,
    output logic [7:0]                 wr_data,
    output logic                       in_end,
    output logic                       truncated
);
    import asmt_pkg::*;

    localparam int CNT_W = $clog2(ESC_WINDOW + 1);
    localparam int Q_W   = $clog2(ESC_WINDOW + 2);
    localparam int AW    = $clog2(ESC_WINDOW);
    localparam int OC_W  = $clog2(OUT_CAPACITY + 1);

    // Colour letter for a parsed number, zero when unknown
    function automatic logic [7:0] colour_code(input logic [6:0] v, input logic neg);
        logic [7:0] code;
        code = 8'h00;
        if (neg && (v != 7'd0))
        begin
            code = 8'h00;
        end
        else
        begin
            case (v)
                7'd0:  code = "n";
                7'd1:  code = "h";
                7'd5:  code = "f";
                7'd7:  code = "i";
                7'd30: code = "x";
                7'd31: code = "r";
                7'd32: code = "g";
                7'd33: code = "y";
                7'd34: code = "b";
                7'd35: code = "m";
                7'd36: code = "c";
                7'd37: code = "w";
                7'd40: code = "X";
                7'd41: code = "R";
                7'd42: code = "G";
                7'd43: code = "Y";
                7'd44: code = "B";
                7'd45: code = "M";
                7'd46: code = "C";
                7'd47: code = "W";
                default: code = 8'h00;
            endcase
        end
        return code;
    endfunction

    // Registers
    logic             mode_reg, mode_next;
    logic             sp_reg, sp_next;
    logic             esc_reg, esc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [6:0]       num_reg, num_next;
    logic [1:0]       phase_reg, phase_next;
    logic             neg_reg, neg_next;
    logic [OC_W-1:0]  oc_reg, oc_next;
    logic             drop_reg, drop_next;
    logic [7:0]       in_byte_reg, in_byte_next;
    logic             in_end_reg, in_end_next;
    asmt_src_t        src_reg, src_next;
    logic [Q_W-1:0]   q_idx_reg, q_idx_next;
    logic [Q_W-1:0]   q_len_reg, q_len_next;
    logic [7:0]       extra_reg, extra_next;
    logic [7:0]       list_reg [3];
    logic [7:0]       list_next [3];
    logic [1:0]       list_n_reg, list_n_next;
    logic [1:0]       list_i_reg, list_i_next;

    // Escape window store
    logic [7:0]       store_mem [ESC_WINDOW];
    logic [7:0]       store_rd_reg;
    logic             store_we;

    logic [7:0]       cur;
    logic             digit;
    logic [3:0]       dval;
    logic [10:0]      acc;
    logic             is_ws;
    logic [7:0]       code;

    // Byte under handling
    always_comb
    begin
        case (src_reg)
            SRC_IN:    cur = in_byte_reg;
            SRC_MEM:   cur = store_rd_reg;
            SRC_EXTRA: cur = extra_reg;
            default:   cur = in_byte_reg;
        endcase
    end

    assign digit = (cur >= CH_0) && (cur <= CH_9);
    assign dval  = cur[3:0];
    assign acc   = ({4'd0, num_reg} << 3) + ({4'd0, num_reg} << 1) + {7'd0, dval};
    assign is_ws = (cur == CH_SP) || ((cur >= CH_TAB) && (cur <= CH_CR));
    assign code  = colour_code(num_reg, neg_reg);

    // Next-state logic for all commands
    always_comb
    begin
        mode_next    = mode_reg;
        sp_next      = sp_reg;
        esc_next     = esc_reg;
        cnt_next     = cnt_reg;
        num_next     = num_reg;
        phase_next   = phase_reg;
        neg_next     = neg_reg;
        oc_next      = oc_reg;
        drop_next    = drop_reg;
        in_byte_next = in_byte_reg;
        in_end_next  = in_end_reg;
        src_next     = src_reg;
        q_idx_next   = q_idx_reg;
        q_len_next   = q_len_reg;
        extra_next   = extra_reg;
        list_next    = list_reg;
        list_n_next  = list_n_reg;
        list_i_next  = list_i_reg;
        store_we     = 1'b0;
        wr_en        = 1'b0;
        wr_data      = list_reg[list_i_reg];

        if (cfg_we)
        begin
            mode_next = cfg_data;
        end

        // New input byte
        if (cmd.accept)
        begin
            in_byte_next = in_data.in_byte;
            in_end_next  = in_data.in_end;
            src_next     = SRC_IN;
            q_idx_next   = '0;
            q_len_next   = '0;
        end

        // Re-read one held byte
        if (cmd.fetch)
        begin
            src_next   = (q_idx_reg == Q_W'(ESC_WINDOW)) ? SRC_EXTRA : SRC_MEM;
            q_idx_next = q_idx_reg + 1'b1;
        end

        // Handle one byte: build up to three output characters
        if (cmd.handle)
        begin
            list_i_next = 2'd0;
            list_n_next = 2'd0;
            if (esc_reg)
            begin
                if (cur == CH_LM)
                begin
                    esc_next = 1'b0;
                    cnt_next = '0;
                    if (mode_reg && (code != 8'h00))
                    begin
                        list_next[0] = CH_PCT;
                        list_next[1] = CH_LC;
                        list_next[2] = code;
                        list_n_next  = 2'd3;
                    end
                end
                else if (cnt_reg < CNT_W'(ESC_WINDOW))
                begin
                    store_we = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg != '0)
                    begin
                        case (phase_reg)
                            PH_START:
                            begin
                                if (is_ws)
                                begin
                                    phase_next = PH_START;
                                end
                                else if ((cur == CH_PLUS) || (cur == CH_MIN))
                                begin
                                    neg_next   = (cur == CH_MIN);
                                    phase_next = PH_SIGN;
                                end
                                else if (digit)
                                begin
                                    num_next   = {3'd0, dval};
                                    phase_next = PH_DIGIT;
                                end
                                else
                                begin
                                    phase_next = PH_DONE;
                                end
                            end
                            PH_SIGN:
                            begin
                                if (digit)
                                begin
                                    num_next   = {3'd0, dval};
                                    phase_next = PH_DIGIT;
                                end
                                else
                                begin
                                    phase_next = PH_DONE;
                                end
                            end
                            PH_DIGIT:
                            begin
                                if (digit)
                                begin
                                    num_next = (acc > 11'd127) ? 7'd127 : acc[6:0];
                                end
                                else
                                begin
                                    phase_next = PH_DONE;
                                end
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                end
                else
                begin
                    // window full: ESC goes out literally, held bytes re-run
                    list_next[0] = CH_ESC;
                    list_n_next  = 2'd1;
                    extra_next   = cur;
                    q_idx_next   = '0;
                    q_len_next   = Q_W'(ESC_WINDOW + 1);
                    esc_next     = 1'b0;
                    cnt_next     = '0;
                end
            end
            else
            begin
                // pending space resolves against this byte
                if (sp_reg)
                begin
                    sp_next = 1'b0;
                    if (cur == CH_SP)
                    begin
                        list_next[0] = CH_PCT;
                        list_next[1] = CH_LB;
                        list_n_next  = 2'd2;
                    end
                    else
                    begin
                        list_next[0] = CH_SP;
                        list_n_next  = 2'd1;
                    end
                end
                if (cur == CH_ESC)
                begin
                    esc_next   = 1'b1;
                    cnt_next   = '0;
                    num_next   = '0;
                    phase_next = PH_START;
                    neg_next   = 1'b0;
                end
                else if (cur == CH_SP)
                begin
                    if (mode_reg)
                    begin
                        sp_next = 1'b1;
                    end
                    else
                    begin
                        list_next[list_n_next] = CH_SP;
                        list_n_next = list_n_next + 1'b1;
                    end
                end
                else if ((cur == CH_PCT) || (cur == CH_LBK) || (cur == CH_RBK) ||
                         (cur == CH_LBR) || (cur == CH_RBR) || (cur == CH_LPR) ||
                         (cur == CH_RPR))
                begin
                    if (mode_reg)
                    begin
                        list_next[list_n_next] = CH_PCT;
                        list_n_next = list_n_next + 1'b1;
                    end
                    list_next[list_n_next] = cur;
                    list_n_next = list_n_next + 1'b1;
                end
                else if (cur == CH_CR)
                begin
                    list_n_next = list_n_next;
                end
                else if (cur == CH_LF)
                begin
                    if (mode_reg)
                    begin
                        list_next[list_n_next] = CH_PCT;
                        list_n_next = list_n_next + 1'b1;
                        list_next[list_n_next] = CH_LR;
                        list_n_next = list_n_next + 1'b1;
                    end
                    else
                    begin
                        list_next[list_n_next] = CH_SP;
                        list_n_next = list_n_next + 1'b1;
                    end
                end
                else
                begin
                    list_next[list_n_next] = cur;
                    list_n_next = list_n_next + 1'b1;
                end
            end
        end

        // Close the string: flush an open sequence, then a pending space
        if (cmd.endchk)
        begin
            list_i_next = 2'd0;
            if (esc_reg)
            begin
                list_next[0] = CH_ESC;
                list_n_next  = 2'd1;
                q_idx_next   = '0;
                q_len_next   = Q_W'(cnt_reg);
                esc_next     = 1'b0;
                cnt_next     = '0;
            end
            else
            begin
                list_next[0] = CH_SP;
                list_n_next  = 2'd1;
                sp_next      = 1'b0;
            end
        end

        // One character to the result buffer, or dropped at a limit
        if (cmd.emit)
        begin
            list_i_next = list_i_reg + 1'b1;
            if ((oc_reg >= OC_W'(OUT_CAPACITY)) || ob_status.full)
            begin
                drop_next = 1'b1;
            end
            else
            begin
                wr_en   = 1'b1;
                oc_next = oc_reg + 1'b1;
            end
        end

        // End of string: per-string state back to its reset values
        if (cmd.finish && in_end_reg)
        begin
            sp_next    = 1'b0;
            esc_next   = 1'b0;
            cnt_next   = '0;
            num_next   = '0;
            phase_next = PH_START;
            neg_next   = 1'b0;
            oc_next    = '0;
            drop_next  = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b1;
            sp_reg     <= 1'b0;
            esc_reg    <= 1'b0;
            cnt_reg    <= '0;
            num_reg    <= '0;
            phase_reg  <= PH_START;
            neg_reg    <= 1'b0;
            oc_reg     <= '0;
            drop_reg   <= 1'b0;
            in_end_reg <= 1'b0;
            src_reg    <= SRC_IN;
            q_idx_reg  <= '0;
            q_len_reg  <= '0;
            list_n_reg <= 2'd0;
            list_i_reg <= 2'd0;
        end
        else
        begin
            mode_reg   <= mode_next;
            sp_reg     <= sp_next;
            esc_reg    <= esc_next;
            cnt_reg    <= cnt_next;
            num_reg    <= num_next;
            phase_reg  <= phase_next;
            neg_reg    <= neg_next;
            oc_reg     <= oc_next;
            drop_reg   <= drop_next;
            in_end_reg <= in_end_next;
            src_reg    <= src_next;
            q_idx_reg  <= q_idx_next;
            q_len_reg  <= q_len_next;
            list_n_reg <= list_n_next;
            list_i_reg <= list_i_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
        extra_reg   <= extra_next;
        list_reg    <= list_next;
    end

    // Window store: written while a sequence collects, read on re-run
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[cnt_reg[AW-1:0]] <= cur;
        end
        if (cmd.fetch)
        begin
            store_rd_reg <= store_mem[q_idx_reg[AW-1:0]];
        end
    end

    assign dp_status.list_done = (list_i_reg == list_n_reg);
    assign dp_status.more      = (q_idx_reg < q_len_reg);
    assign dp_status.in_end    = in_end_reg;
    assign dp_status.end_idle  = !esc_reg && !sp_reg;
    assign in_end              = in_end_reg;
    assign truncated           = drop_reg;

endmodule

`default_nettype wire

// ===== src/asmt_outbuf.sv =====
// ----------------------------------------------------------------------------
// asmt_outbuf
// Collects the characters of one step, then plays them out on the result
// channel with run, string and drop flags; a bare end marker when empty.
// ----------------------------------------------------------------------------
`default_nettype none

module asmt_outbuf (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        wr_en,
    input  wire  [7:0]                 wr_data,
    input  wire                        drain_start,
    input  wire                        in_end,
    input  wire                        truncated,
    input  wire                        out_stall,
    output logic                       out_valid,
    output asmt_pkg::asmt_out_t        out_data,
    output asmt_pkg::asmt_ob_status_t  ob_status
);
    import asmt_pkg::*;

    logic [7:0]       res_mem [MAX_RESULTS];
    logic [RES_W-1:0] res_n_reg, res_n_next;
    logic [RES_W-1:0] rd_idx_reg, rd_idx_next;
    logic             valid_reg, valid_next;
    logic             last_reg, last_next;
    logic             marker_reg, marker_next;
    logic [7:0]       rd_data_reg;
    logic             rd_en;
    logic [RES_W-1:0] rd_addr;
    logic             transfer;

    assign transfer = valid_reg && !out_stall;

    // Fill and play-out control
    always_comb
    begin
        res_n_next  = res_n_reg;
        rd_idx_next = rd_idx_reg;
        valid_next  = valid_reg;
        last_next   = last_reg;
        marker_next = marker_reg;
        rd_en       = 1'b0;
        rd_addr     = rd_idx_reg;

        if (wr_en)
        begin
            res_n_next = res_n_reg + 1'b1;
        end

        if (drain_start)
        begin
            valid_next = 1'b1;
            if (res_n_reg == '0)
            begin
                marker_next = 1'b1;
                last_next   = 1'b1;
            end
            else
            begin
                marker_next = 1'b0;
                rd_en       = 1'b1;
                rd_addr     = '0;
                rd_idx_next = RES_W'(1);
                last_next   = (res_n_reg == RES_W'(1));
            end
        end
        else if (transfer)
        begin
            if (last_reg)
            begin
                valid_next  = 1'b0;
                res_n_next  = '0;
                marker_next = 1'b0;
            end
            else
            begin
                rd_en       = 1'b1;
                rd_idx_next = rd_idx_reg + 1'b1;
                last_next   = ((rd_idx_reg + 1'b1) == res_n_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_n_reg  <= '0;
            rd_idx_reg <= '0;
            valid_reg  <= 1'b0;
            last_reg   <= 1'b0;
            marker_reg <= 1'b0;
        end
        else
        begin
            res_n_reg  <= res_n_next;
            rd_idx_reg <= rd_idx_next;
            valid_reg  <= valid_next;
            last_reg   <= last_next;
            marker_reg <= marker_next;
        end
    end

    // Result memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            res_mem[res_n_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= res_mem[rd_addr];
        end
    end

    assign out_valid            = valid_reg;
    assign out_data.out_char    = marker_reg ? 8'h00 : rd_data_reg;
    assign out_data.char_valid  = !marker_reg;
    assign out_data.run_last    = last_reg;
    assign out_data.string_done = last_reg && in_end;
    assign out_data.truncated   = truncated;

    assign ob_status.has_results = (res_n_reg != '0);
    assign ob_status.full        = (res_n_reg == RES_W'(MAX_RESULTS));
    assign ob_status.drain_done  = transfer && last_reg;

endmodule

`default_nettype wire

// ===== src/ansi_sgr_to_markup_translator.sv =====
// ----------------------------------------------------------------------------
// ansi_sgr_to_markup_translator
// Byte-serial translator of ANSI SGR escape sequences into percent markup,
// or a stripped copy, selected by the translate_mode register.
//
// Input channel in_valid/in_stall/in_data: one source byte per transfer,
// in_end on the last byte of a string. Result channel out_valid/out_stall/
// out_data: the characters caused by that byte, run_last on the last one,
// string_done on the last result of a string; a closing byte with no
// characters gives one end marker with char_valid low.
// Configuration: cfg_valid/cfg_ready/cfg_data writes translate_mode; ready
// only while no byte is in flight.
// Flow: one byte at a time. A plain byte is collected (accept, handle,
// emit per character, decide), then its results are drained; a window
// overflow or unterminated flush re-reads each held byte from the window
// store and handles and emits it in turn. The input is stalled until
// every result of the byte is taken; a stalled receiver holds the current
// result on the output register.
// Reset selects translate mode and clears all per-string state.
// ----------------------------------------------------------------------------
`default_nettype none

module ansi_sgr_to_markup_translator #(
    parameter int ESC_WINDOW   = asmt_pkg::ESC_WINDOW_DEF,
    parameter int OUT_CAPACITY = asmt_pkg::OUT_CAPACITY_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  asmt_pkg::asmt_in_t   in_data,
    output logic                 out_valid,
    input  wire                  out_stall,
    output asmt_pkg::asmt_out_t  out_data,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire                  cfg_data
);
    import asmt_pkg::*;

    asmt_cmd_t       cmd;
    asmt_dp_status_t dp_status;
    asmt_ob_status_t ob_status;
    logic            idle;
    logic            wr_en;
    logic [7:0]      wr_data;
    logic            in_end;
    logic            truncated;

    assign in_stall  = !idle;
    assign cfg_ready = idle;

    asmt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .dp_status (dp_status),
        .ob_status (ob_status),
        .cmd       (cmd),
        .idle      (idle)
    );

    asmt_datapath #(
        .ESC_WINDOW   (ESC_WINDOW),
        .OUT_CAPACITY (OUT_CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .ob_status (ob_status),
        .dp_status (dp_status),
        .wr_en     (wr_en),
        .wr_data   (wr_data),
        .in_end    (in_end),
        .truncated (truncated)
    );

    asmt_outbuf u_outbuf (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_data     (wr_data),
        .drain_start (cmd.drain_start),
        .in_end      (in_end),
        .truncated   (truncated),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_data    (out_data),
        .ob_status   (ob_status)
    );

endmodule

`default_nettype wire
